/* rtl/hsv_pkg.sv */
package hsv_pkg;

  // field widths of the pixel and of the result word
  localparam int PIX_W = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;

  // largest codes the result fields can carry
  localparam logic [HUE_W-1:0] HUE_FIELD_MAX = 15'h7fff;
  localparam logic [SAT_W-1:0] SAT_FIELD_MAX = 16'hffff;

  // width of 60 * a, where a is at most 510
  localparam int HUE_NUM_W = 15;

  // hue sector: which channel is the max, and for red which side of zero
  typedef logic [1:0] hsv_sector_t;
  localparam hsv_sector_t SEC_RED_UP   = 2'd0;  // base 0 degrees
  localparam hsv_sector_t SEC_RED_DOWN = 2'd1;  // base 300 degrees
  localparam hsv_sector_t SEC_GREEN    = 2'd2;  // base 60 degrees
  localparam hsv_sector_t SEC_BLUE     = 2'd3;  // base 180 degrees

  // base angle in whole degrees for each sector
  localparam logic [8:0] DEG_RED_UP   = 9'd0;
  localparam logic [8:0] DEG_RED_DOWN = 9'd300;
  localparam logic [8:0] DEG_GREEN    = 9'd60;
  localparam logic [8:0] DEG_BLUE     = 9'd180;

  // side data that rides along the divider chain
  typedef struct packed {
    hsv_sector_t      sector;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] delta;
  } hsv_side_t;

endpackage

/* rtl/hsv_prep.sv */
module hsv_prep #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16,
  parameter int N             = 24
) (
  input  logic [hsv_pkg::PIX_W-1:0] red,
  input  logic [hsv_pkg::PIX_W-1:0] green,
  input  logic [hsv_pkg::PIX_W-1:0] blue,
  output hsv_pkg::hsv_side_t        side,
  output logic [N-1:0]              dvd_h,
  output logic [N-1:0]              dvd_s
);
  import hsv_pkg::*;

  logic [PIX_W-1:0]     mx_rg;
  logic [PIX_W-1:0]     mn_rg;
  logic [PIX_W-1:0]     mx;
  logic [PIX_W-1:0]     mn;
  logic [PIX_W-1:0]     delta;
  logic [PIX_W-1:0]     add_term;
  logic [PIX_W-1:0]     sub_term;
  logic                 use_delta;
  hsv_sector_t          sector;
  logic [9:0]           a_sum;
  logic [8:0]           a_val;
  logic [HUE_NUM_W-1:0] num;

  // find the largest and smallest channel
  assign mx_rg = (red > green) ? red : green;
  assign mn_rg = (red < green) ? red : green;
  assign mx    = (mx_rg > blue) ? mx_rg : blue;
  assign mn    = (mn_rg < blue) ? mn_rg : blue;
  assign delta = mx - mn;

  // pick the sector; the offset within it is a = [delta] + add - sub, 0..2*delta
  always_comb begin
    sector    = SEC_BLUE;
    use_delta = 1'b1;
    add_term  = red;
    sub_term  = green;
    if (red == mx) begin
      add_term = green;
      sub_term = blue;
      if (green >= blue) begin
        sector    = SEC_RED_UP;
        use_delta = 1'b0;
      end else begin
        sector    = SEC_RED_DOWN;
      end
    end else if (green == mx) begin
      sector   = SEC_GREEN;
      add_term = blue;
      sub_term = red;
    end
  end

  assign a_sum = (use_delta ? {2'b00, delta} : 10'd0) + {2'b00, add_term}
                 - {2'b00, sub_term};
  assign a_val = a_sum[8:0];

  // 60 * a as 64a - 4a
  assign num = ({6'd0, a_val} << 6) - ({6'd0, a_val} << 2);

  // dividends scaled so both quotients come out of the last cell
  assign dvd_h = {{(N-HUE_NUM_W){1'b0}}, num} << HUE_FRAC_BITS;
  assign dvd_s = {{(N-PIX_W){1'b0}}, delta} << SAT_BITS;

  assign side.sector = sector;
  assign side.mx     = mx;
  assign side.delta  = delta;

endmodule

/* rtl/hsv_cell.sv */
module hsv_cell #(
  parameter int N = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  hsv_pkg::hsv_side_t           up_side,
  input  logic [N-1:0]                 up_dvd_h,
  input  logic [N-1:0]                 up_dvd_s,
  input  logic [hsv_pkg::PIX_W-1:0]    up_rem_h,
  input  logic [hsv_pkg::PIX_W-1:0]    up_rem_s,
  input  logic [N-1:0]                 up_quo_h,
  input  logic [N-1:0]                 up_quo_s,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output hsv_pkg::hsv_side_t           dn_side,
  output logic [N-1:0]                 dn_dvd_h,
  output logic [N-1:0]                 dn_dvd_s,
  output logic [hsv_pkg::PIX_W-1:0]    dn_rem_h,
  output logic [hsv_pkg::PIX_W-1:0]    dn_rem_s,
  output logic [N-1:0]                 dn_quo_h,
  output logic [N-1:0]                 dn_quo_s
);
  import hsv_pkg::*;

  logic             valid_r;
  hsv_side_t        side_r;
  logic [N-1:0]     dvd_h_r;
  logic [N-1:0]     dvd_s_r;
  logic [PIX_W-1:0] rem_h_r;
  logic [PIX_W-1:0] rem_s_r;
  logic [N-1:0]     quo_h_r;
  logic [N-1:0]     quo_s_r;

  logic [PIX_W:0]   sh_h;
  logic [PIX_W:0]   sh_s;
  logic [PIX_W:0]   df_h;
  logic [PIX_W:0]   df_s;
  logic             ge_h;
  logic             ge_s;
  logic [PIX_W-1:0] rem_h_nxt;
  logic [PIX_W-1:0] rem_s_nxt;
  logic [N-1:0]     quo_h_nxt;
  logic [N-1:0]     quo_s_nxt;

  // hue step: bring down one dividend bit, subtract delta if it fits
  assign sh_h      = {up_rem_h, up_dvd_h[N-1]};
  assign df_h      = sh_h - {1'b0, up_side.delta};
  assign ge_h      = sh_h >= {1'b0, up_side.delta};
  assign rem_h_nxt = ge_h ? df_h[PIX_W-1:0] : sh_h[PIX_W-1:0];
  assign quo_h_nxt = {up_quo_h[N-2:0], ge_h};

  // saturation step: same against max
  assign sh_s      = {up_rem_s, up_dvd_s[N-1]};
  assign df_s      = sh_s - {1'b0, up_side.mx};
  assign ge_s      = sh_s >= {1'b0, up_side.mx};
  assign rem_s_nxt = ge_s ? df_s[PIX_W-1:0] : sh_s[PIX_W-1:0];
  assign quo_s_nxt = {up_quo_s[N-2:0], ge_s};

  // take a word when empty or when the neighbor takes ours
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // advance the payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      side_r  <= up_side;
      dvd_h_r <= up_dvd_h << 1;
      dvd_s_r <= up_dvd_s << 1;
      rem_h_r <= rem_h_nxt;
      rem_s_r <= rem_s_nxt;
      quo_h_r <= quo_h_nxt;
      quo_s_r <= quo_s_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_side  = side_r;
  assign dn_dvd_h = dvd_h_r;
  assign dn_dvd_s = dvd_s_r;
  assign dn_rem_h = rem_h_r;
  assign dn_rem_s = rem_s_r;
  assign dn_quo_h = quo_h_r;
  assign dn_quo_s = quo_s_r;

endmodule

/* rtl/hsv_finish.sv */
module hsv_finish #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16,
  parameter int N             = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  hsv_pkg::hsv_side_t            up_side,
  input  logic [N-1:0]                  up_quo_h,
  input  logic [N-1:0]                  up_quo_s,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsv_pkg::HUE_W-1:0]     out_hue,
  output logic [hsv_pkg::SAT_W-1:0]     out_saturation,
  output logic [hsv_pkg::PIX_W-1:0]     out_brightness
);
  import hsv_pkg::*;

  localparam logic [N-1:0] SAT_CAP = (SAT_BITS >= SAT_W) ? N'(SAT_FIELD_MAX)
                                                         : N'((1 << SAT_BITS) - 1);
  localparam logic [N+1:0] HUE_CAP = {{(N+2-HUE_W){1'b0}}, HUE_FIELD_MAX};

  logic             valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r;
  logic [PIX_W-1:0] bright_r;

  logic [8:0]       base_deg;
  logic [N+1:0]     hue_sum;
  logic [HUE_W-1:0] hue_nxt;
  logic [N-1:0]     sat_clip;
  logic [SAT_W-1:0] sat_nxt;

  // base angle of the sector
  always_comb begin
    case (up_side.sector)
      SEC_RED_UP:   base_deg = DEG_RED_UP;
      SEC_RED_DOWN: base_deg = DEG_RED_DOWN;
      SEC_GREEN:    base_deg = DEG_GREEN;
      SEC_BLUE:     base_deg = DEG_BLUE;
      default:      base_deg = DEG_RED_UP;
    endcase
  end

  // add the scaled base, clip to the field; gray pixels have no hue
  assign hue_sum = ({{(N-7){1'b0}}, base_deg} << HUE_FRAC_BITS) + {2'b00, up_quo_h};
  assign hue_nxt = (up_side.delta == '0) ? '0 :
                   (hue_sum > HUE_CAP)   ? HUE_FIELD_MAX : hue_sum[HUE_W-1:0];

  // clip saturation; black pixels have none
  assign sat_clip = (up_quo_s > SAT_CAP) ? SAT_CAP : up_quo_s;
  assign sat_nxt  = (up_side.mx == '0) ? '0 : sat_clip[SAT_W-1:0];

  // output register frees as soon as its word is taken
  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= up_side.mx;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// RGB to HSV conversion, one 8-bit pixel per word, one word per clock
// sustained while out_stall is low. brightness is the largest channel;
// saturation is floor(delta * 2^SAT_BITS / max), clipped to its field
// (0 for black); hue is degrees * 2^HUE_FRAC_BITS, floored, in 0 up to
// below 360 degrees (0 for gray). Both quotients are formed by a chain of
// restoring-divide cells, one quotient bit per cell, with N = max(15 +
// HUE_FRAC_BITS, 8 + SAT_BITS) cells (24 at the defaults), followed by an
// output register: N + 1 registers in all. Each cell is a stage with its
// own valid, so empty stages fill while the output stalls; in_stall
// follows out_stall back through the chain within the same cycle once
// every stage is full.
module rgb_to_hsv_converter #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hsv_pkg::PIX_W-1:0]     in_red,
  input  logic [hsv_pkg::PIX_W-1:0]     in_green,
  input  logic [hsv_pkg::PIX_W-1:0]     in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hsv_pkg::HUE_W-1:0]     out_hue,
  output logic [hsv_pkg::SAT_W-1:0]     out_saturation,
  output logic [hsv_pkg::PIX_W-1:0]     out_brightness
);
  import hsv_pkg::*;

  localparam int N_HUE = HUE_NUM_W + HUE_FRAC_BITS;
  localparam int N_SAT = PIX_W + SAT_BITS;
  localparam int N     = (N_HUE > N_SAT) ? N_HUE : N_SAT;

  // per-stage links; index k feeds cell k, index N feeds the output stage
  logic             vld_a  [0:N];
  logic             rdy_a  [0:N];
  hsv_side_t        side_a [0:N];
  logic [N-1:0]     dvdh_a [0:N];
  logic [N-1:0]     dvds_a [0:N];
  logic [PIX_W-1:0] remh_a [0:N];
  logic [PIX_W-1:0] rems_a [0:N];
  logic [N-1:0]     quoh_a [0:N];
  logic [N-1:0]     quos_a [0:N];

  // front end: sort channels, pick sector, form dividends
  hsv_prep #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_BITS      (SAT_BITS),
    .N             (N)
  ) u_prep (
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .side  (side_a[0]),
    .dvd_h (dvdh_a[0]),
    .dvd_s (dvds_a[0])
  );

  assign vld_a[0]  = in_valid;
  assign remh_a[0] = '0;
  assign rems_a[0] = '0;
  assign quoh_a[0] = '0;
  assign quos_a[0] = '0;
  assign in_stall  = !rdy_a[0];

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < N; k++) begin : g_cell
    hsv_cell #(
      .N (N)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_a[k]),
      .up_ready (rdy_a[k]),
      .up_side  (side_a[k]),
      .up_dvd_h (dvdh_a[k]),
      .up_dvd_s (dvds_a[k]),
      .up_rem_h (remh_a[k]),
      .up_rem_s (rems_a[k]),
      .up_quo_h (quoh_a[k]),
      .up_quo_s (quos_a[k]),
      .dn_valid (vld_a[k+1]),
      .dn_ready (rdy_a[k+1]),
      .dn_side  (side_a[k+1]),
      .dn_dvd_h (dvdh_a[k+1]),
      .dn_dvd_s (dvds_a[k+1]),
      .dn_rem_h (remh_a[k+1]),
      .dn_rem_s (rems_a[k+1]),
      .dn_quo_h (quoh_a[k+1]),
      .dn_quo_s (quos_a[k+1])
    );
  end

  // back end: add sector base, clip, hold the result word
  hsv_finish #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_BITS      (SAT_BITS),
    .N             (N)
  ) u_finish (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (vld_a[N]),
    .up_ready       (rdy_a[N]),
    .up_side        (side_a[N]),
    .up_quo_h       (quoh_a[N]),
    .up_quo_s       (quos_a[N]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule
